@@ rtl/r64fe_pkg.sv @@
// ----------------------------------------------------------------------------
// r64fe_pkg
// Shared constants, types and the character mapping of the radix-64
// fragment encoder.
// ----------------------------------------------------------------------------
package r64fe_pkg;

    localparam int MAX_MSG_BYTES = 32768;
    localparam int HEADER_CHARS  = 2 + (48 / 6);
    localparam int MAX_FRAGMENTS = 62;
    localparam int MIN_MTU       = 12;

    localparam int MTU_W      = 11;
    localparam int NONCE_W    = 48;
    localparam int MLEN_W     = 15;
    localparam int LEN_W      = 16;
    localparam int FB_W       = 11;
    localparam int FNUM_W     = 6;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LINE_MTU = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MSG_LEN  = 2'd2;

    // position of a byte inside its three-byte group
    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_DOT   = 8'h2e;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;

    typedef struct packed {
        logic [MTU_W-1:0]   line_mtu;
        logic [NONCE_W-1:0] nonce_value;
        logic [MLEN_W-1:0]  message_length;
    } cfg_t;

    // one classified byte, handed from front to back
    typedef struct packed {
        logic [7:0]        data;
        logic              ovf;
        logic              msg_end;
        logic              frag_start;
        logic              frag_end;
        logic [1:0]        phase;
        logic [FNUM_W-1:0] frag_num;
        logic [FNUM_W-1:0] total_m1;
    } item_t;

    function automatic logic [7:0] code_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd10) begin
            c = CHAR_ZERO + {2'b00, v};
        end else if (v < 6'd36) begin
            c = CHAR_LOW_A + {2'b00, v} - 8'd10;
        end else if (v < 6'd62) begin
            c = CHAR_UP_A + {2'b00, v} - 8'd36;
        end else if (v == 6'd62) begin
            c = CHAR_DOT;
        end else begin
            c = CHAR_PLUS;
        end
        return c;
    endfunction

endpackage

@@ rtl/r64fe_front.sv @@
// ----------------------------------------------------------------------------
// r64fe_front
// Accepts message bytes, sizes the message on its first byte and tags each
// byte with its fragment position before handing it to the queue.
// ----------------------------------------------------------------------------
module r64fe_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  r64fe_pkg::cfg_t      cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_data_byte,
    output logic                 item_valid,
    input  logic                 item_ready,
    output r64fe_pkg::item_t     item
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_PUSH  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [r64fe_pkg::MLEN_W-1:0] msg_pos_reg, msg_pos_next;
    logic [r64fe_pkg::FB_W-1:0]   frag_pos_reg, frag_pos_next;
    logic [1:0]                   phase_reg, phase_next;
    logic [r64fe_pkg::FNUM_W-1:0] frag_num_reg, frag_num_next;
    logic [r64fe_pkg::FB_W-1:0]   fb_reg, fb_next;
    logic                         ovf_reg, ovf_next;
    logic [r64fe_pkg::MLEN_W-1:0] rem_reg, rem_next;
    logic [r64fe_pkg::FNUM_W-1:0] quot_reg, quot_next;
    logic [2:0]                   step_reg, step_next;
    logic [7:0]                   data_reg, data_next;

    logic [r64fe_pkg::LEN_W-1:0]  len_eff;
    logic [r64fe_pkg::MTU_W-1:0]  mtu_eff;
    logic [12:0]                  mtu_x3;
    logic [r64fe_pkg::FB_W-1:0]   fb_calc;
    logic [16:0]                  limit;
    logic [16:0]                  trial;
    logic                         msg_end;
    logic                         frag_end;

    always_comb begin
        if (cfg.message_length == '0) begin
            len_eff = 16'd1;
        end else if ({1'b0, cfg.message_length} > 16'(r64fe_pkg::MAX_MSG_BYTES)) begin
            len_eff = 16'(r64fe_pkg::MAX_MSG_BYTES);
        end else begin
            len_eff = {1'b0, cfg.message_length};
        end
    end

    assign mtu_eff = (cfg.line_mtu < 11'(r64fe_pkg::MIN_MTU)) ?
                     11'(r64fe_pkg::MIN_MTU) : cfg.line_mtu;
    // (mtu - 10) * 6 / 8 bytes per fragment
    assign mtu_x3  = 13'(mtu_eff - 11'(r64fe_pkg::HEADER_CHARS)) * 13'd3;
    assign fb_calc = 11'(mtu_x3 >> 2);

    assign limit = 17'(fb_reg) * 17'(r64fe_pkg::MAX_FRAGMENTS);
    assign trial = 17'(fb_reg) << step_reg;

    assign msg_end  = (16'(msg_pos_reg) + 16'd1) >= len_eff;
    assign frag_end = msg_end || ((12'(frag_pos_reg) + 12'd1) >= 12'(fb_reg));

    assign s_ready    = (state_reg == ST_IDLE);
    assign item_valid = (state_reg == ST_PUSH);

    always_comb begin
        item.data       = data_reg;
        item.ovf        = ovf_reg;
        item.msg_end    = msg_end;
        item.frag_start = (frag_pos_reg == '0);
        item.frag_end   = frag_end;
        item.phase      = phase_reg;
        item.frag_num   = frag_num_reg;
        item.total_m1   = quot_reg;
    end

    always_comb begin
        state_next    = state_reg;
        msg_pos_next  = msg_pos_reg;
        frag_pos_next = frag_pos_reg;
        phase_next    = phase_reg;
        frag_num_next = frag_num_reg;
        fb_next       = fb_reg;
        ovf_next      = ovf_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        step_next     = step_reg;
        data_next     = data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    data_next = s_data_byte;
                    if (msg_pos_reg == '0) begin
                        fb_next       = fb_calc;
                        frag_pos_next = '0;
                        frag_num_next = '0;
                        phase_next    = r64fe_pkg::PHASE_0;
                        state_next    = ST_CHECK;
                    end else begin
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_CHECK: begin
                // more than 62 fragments exactly when len > 62 * fb
                ovf_next   = {1'b0, len_eff} > limit;
                rem_next   = 15'(len_eff - 16'd1);
                quot_next  = '0;
                step_next  = 3'd5;
                state_next = ({1'b0, len_eff} > limit) ? ST_PUSH : ST_DIV;
            end
            ST_DIV: begin
                // one quotient bit per cycle: total - 1 = (len - 1) / fb
                if (17'(rem_reg) >= trial) begin
                    rem_next            = 15'(17'(rem_reg) - trial);
                    quot_next[step_reg] = 1'b1;
                end
                if (step_reg == '0) begin
                    state_next = ST_PUSH;
                end else begin
                    step_next = step_reg - 3'd1;
                end
            end
            ST_PUSH: begin
                if (item_ready) begin
                    state_next = ST_IDLE;
                    if (msg_end) begin
                        msg_pos_next  = '0;
                        frag_pos_next = '0;
                        frag_num_next = '0;
                        phase_next    = r64fe_pkg::PHASE_0;
                        ovf_next      = 1'b0;
                    end else begin
                        msg_pos_next = msg_pos_reg + 15'd1;
                        if (!ovf_reg) begin
                            if (frag_end) begin
                                frag_pos_next = '0;
                                frag_num_next = frag_num_reg + 6'd1;
                                phase_next    = r64fe_pkg::PHASE_0;
                            end else begin
                                frag_pos_next = frag_pos_reg + 11'd1;
                                phase_next    = (phase_reg == r64fe_pkg::PHASE_2) ?
                                                r64fe_pkg::PHASE_0 : phase_reg + 2'd1;
                            end
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            msg_pos_reg  <= '0;
            frag_pos_reg <= '0;
            phase_reg    <= '0;
            frag_num_reg <= '0;
            fb_reg       <= '0;
            ovf_reg      <= 1'b0;
            quot_reg     <= '0;
            step_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            msg_pos_reg  <= msg_pos_next;
            frag_pos_reg <= frag_pos_next;
            phase_reg    <= phase_next;
            frag_num_reg <= frag_num_next;
            fb_reg       <= fb_next;
            ovf_reg      <= ovf_next;
            quot_reg     <= quot_next;
            step_reg     <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        data_reg <= data_next;
    end

endmodule

@@ rtl/r64fe_queue.sv @@
// ----------------------------------------------------------------------------
// r64fe_queue
// Short FIFO of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module r64fe_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  r64fe_pkg::item_t  push_item,
    output logic              pop_valid,
    input  logic              pop_ready,
    output r64fe_pkg::item_t  pop_item
);

    r64fe_pkg::item_t             entry_reg [r64fe_pkg::Q_DEPTH];
    logic [r64fe_pkg::Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [r64fe_pkg::Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [r64fe_pkg::Q_AW:0]     count_reg, count_next;
    logic                         push;
    logic                         pop;

    assign push_ready = (count_reg != (r64fe_pkg::Q_AW + 1)'(r64fe_pkg::Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];

    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/r64fe_back.sv @@
// ----------------------------------------------------------------------------
// r64fe_back
// Expands each queued byte into its characters (or one error result), one
// per cycle unless m_ready stalls, through a registered output stage.
// ----------------------------------------------------------------------------
module r64fe_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [r64fe_pkg::NONCE_W-1:0]       nonce_value,
    input  logic                                item_valid,
    output logic                                item_pop,
    input  r64fe_pkg::item_t                    item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_out_char,
    output logic                                m_char_valid,
    output logic                                m_fragment_end,
    output logic                                m_message_end,
    output logic                                m_too_many_fragments,
    output logic                                m_last_of_run
);

    logic [r64fe_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [3:0]                  held_reg, held_next;
    logic                        m_valid_reg, m_valid_next;
    logic [7:0]                  char_reg, char_next;
    logic                        cv_reg, cv_next;
    logic                        fe_reg, fe_next;
    logic                        me_reg, me_next;
    logic                        tmf_reg, tmf_next;
    logic                        lor_reg, lor_next;

    logic                        load;
    logic [r64fe_pkg::CNT_W-1:0] hdr;
    logic [r64fe_pkg::CNT_W-1:0] body_n;
    logic [r64fe_pkg::CNT_W-1:0] count;
    logic                        last;
    logic [r64fe_pkg::CNT_W-1:0] k;
    logic [2:0]                  nidx;
    logic [5:0]                  nonce_bits;
    logic [5:0]                  first_bits;
    logic [5:0]                  second_bits;
    logic [5:0]                  value;

    assign load   = item_valid && (!m_valid_reg || m_ready);
    assign hdr    = item.frag_start ? 4'(r64fe_pkg::HEADER_CHARS) : 4'd0;
    assign body_n = ((item.phase == r64fe_pkg::PHASE_2) || item.frag_end) ? 4'd2 : 4'd1;
    assign count  = item.ovf ? 4'd1 : hdr + body_n;
    assign last   = (idx_reg == count - 4'd1);
    assign k      = idx_reg - hdr;
    assign nidx   = 3'(idx_reg - 4'd2);

    always_comb begin
        unique case (nidx)
            3'd0: nonce_bits = nonce_value[5:0];
            3'd1: nonce_bits = nonce_value[11:6];
            3'd2: nonce_bits = nonce_value[17:12];
            3'd3: nonce_bits = nonce_value[23:18];
            3'd4: nonce_bits = nonce_value[29:24];
            3'd5: nonce_bits = nonce_value[35:30];
            3'd6: nonce_bits = nonce_value[41:36];
            3'd7: nonce_bits = nonce_value[47:42];
            default: nonce_bits = '0;
        endcase
    end

    // body characters, least significant bits first
    always_comb begin
        unique case (item.phase)
            r64fe_pkg::PHASE_1: begin
                first_bits  = {item.data[3:0], held_reg[1:0]};
                second_bits = {2'b00, item.data[7:4]};
            end
            r64fe_pkg::PHASE_2: begin
                first_bits  = {item.data[1:0], held_reg};
                second_bits = item.data[7:2];
            end
            default: begin
                first_bits  = item.data[5:0];
                second_bits = {4'b0000, item.data[7:6]};
            end
        endcase
    end

    always_comb begin
        if (idx_reg < hdr) begin
            if (idx_reg == 4'd0) begin
                value = item.frag_num;
            end else if (idx_reg == 4'd1) begin
                value = item.total_m1;
            end else begin
                value = nonce_bits;
            end
        end else if (k == 4'd0) begin
            value = first_bits;
        end else begin
            value = second_bits;
        end
    end

    always_comb begin
        idx_next     = idx_reg;
        held_next    = held_reg;
        m_valid_next = m_valid_reg;
        char_next    = char_reg;
        cv_next      = cv_reg;
        fe_next      = fe_reg;
        me_next      = me_reg;
        tmf_next     = tmf_reg;
        lor_next     = lor_reg;
        if (load) begin
            m_valid_next = 1'b1;
            idx_next     = last ? 4'd0 : idx_reg + 4'd1;
            if (item.ovf) begin
                char_next = 8'd0;
                cv_next   = 1'b0;
                fe_next   = 1'b0;
                me_next   = item.msg_end;
                tmf_next  = 1'b1;
                lor_next  = 1'b1;
            end else begin
                char_next = r64fe_pkg::code_char(value);
                cv_next   = 1'b1;
                fe_next   = last && item.frag_end;
                me_next   = last && item.msg_end;
                tmf_next  = 1'b0;
                lor_next  = last;
                if (last) begin
                    held_next = (item.phase == r64fe_pkg::PHASE_0) ?
                                {2'b00, item.data[7:6]} : item.data[7:4];
                end
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
        char_reg <= char_next;
        cv_reg   <= cv_next;
        fe_reg   <= fe_next;
        me_reg   <= me_next;
        tmf_reg  <= tmf_next;
        lor_reg  <= lor_next;
    end

    assign item_pop             = load && last;
    assign m_valid              = m_valid_reg;
    assign m_out_char           = char_reg;
    assign m_char_valid         = cv_reg;
    assign m_fragment_end       = fe_reg;
    assign m_message_end        = me_reg;
    assign m_too_many_fragments = tmf_reg;
    assign m_last_of_run        = lor_reg;

endmodule

@@ rtl/radix64_fragment_encoder.sv @@
// ----------------------------------------------------------------------------
// radix64_fragment_encoder
// Cuts a message into fragments and emits each as radix-64 text with a
// fragment header and the nonce.
// ----------------------------------------------------------------------------
//  channel   ports                        role
//  -------   --------------------------   ----------------------------------
//  s_        s_valid s_ready s_data_byte  message bytes in, one per transfer
//  m_        m_valid m_ready m_* fields   characters or error results out
//  cfg_      cfg_we cfg_index cfg_wdata   register writes, no wait
//
//  Timing: a byte inside a message is accepted, then pushed into the queue;
//  the first byte of a message also passes ST_CHECK and, unless it has too
//  many fragments, ST_DIV, the one-bit-per-cycle fragment count division. The
//  back emits one result per cycle unless m_ready stalls, 1 to 12 per byte,
//  so a fragment start (10 header characters) is set by the output rate and
//  absorbed by the 4-deep queue. Reset is synchronous and clears all control
//  state; stalls on m_ready hold the output register and fill the queue.
// ----------------------------------------------------------------------------
module radix64_fragment_encoder (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_data_byte,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [7:0]                           m_out_char,
    output logic                                 m_char_valid,
    output logic                                 m_fragment_end,
    output logic                                 m_message_end,
    output logic                                 m_too_many_fragments,
    output logic                                 m_last_of_run,
    input  logic                                 cfg_we,
    input  logic [r64fe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [r64fe_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // configuration registers
    logic [r64fe_pkg::MTU_W-1:0]   line_mtu_reg, line_mtu_next;
    logic [r64fe_pkg::NONCE_W-1:0] nonce_reg, nonce_next;
    logic [r64fe_pkg::MLEN_W-1:0]  msg_len_reg, msg_len_next;
    r64fe_pkg::cfg_t               cfg;

    // front to queue, queue to back
    logic                          fr_valid;
    logic                          fr_ready;
    r64fe_pkg::item_t              fr_item;
    logic                          bk_valid;
    logic                          bk_pop;
    r64fe_pkg::item_t              bk_item;

    always_comb begin
        line_mtu_next = line_mtu_reg;
        nonce_next    = nonce_reg;
        msg_len_next  = msg_len_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                r64fe_pkg::REG_LINE_MTU: line_mtu_next = cfg_wdata[r64fe_pkg::MTU_W-1:0];
                r64fe_pkg::REG_NONCE:    nonce_next    = cfg_wdata;
                r64fe_pkg::REG_MSG_LEN:  msg_len_next  = cfg_wdata[r64fe_pkg::MLEN_W-1:0];
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_mtu_reg <= 11'd64;
            nonce_reg    <= '0;
            msg_len_reg  <= 15'd1;
        end else begin
            line_mtu_reg <= line_mtu_next;
            nonce_reg    <= nonce_next;
            msg_len_reg  <= msg_len_next;
        end
    end

    always_comb begin
        cfg.line_mtu       = line_mtu_reg;
        cfg.nonce_value    = nonce_reg;
        cfg.message_length = msg_len_reg;
    end

    // accept and classify: message sizing, fragment and group position
    r64fe_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .item_valid  (fr_valid),
        .item_ready  (fr_ready),
        .item        (fr_item)
    );

    // decouple the two sides so each can stall on its own
    r64fe_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_item  (fr_item),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_pop),
        .pop_item   (bk_item)
    );

    // expand each byte into header and body characters
    r64fe_back u_back (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .nonce_value          (cfg.nonce_value),
        .item_valid           (bk_valid),
        .item_pop             (bk_pop),
        .item                 (bk_item),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_out_char           (m_out_char),
        .m_char_valid         (m_char_valid),
        .m_fragment_end       (m_fragment_end),
        .m_message_end        (m_message_end),
        .m_too_many_fragments (m_too_many_fragments),
        .m_last_of_run        (m_last_of_run)
    );

    // a fragment or message end always closes the run of its byte
    a_frag_end_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_fragment_end) |-> m_last_of_run)
        else $error("fragment end without end of run");

    a_msg_end_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_message_end) |-> m_last_of_run)
        else $error("message end without end of run");

    // an error result carries no character and no fragment end
    a_error_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_too_many_fragments) |-> (!m_char_valid && !m_fragment_end))
        else $error("error result carries character data");

endmodule
